FILE: rtl/sas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sas_pkg: shared types and constants for the shape area sorter
// Record layouts, field widths, shape codes and register indexes.
// ----------------------------------------------------------------------------
package sas_pkg;

  localparam int KindW = 2;
  localparam int SideW = 8;
  localparam int CoefW = 18;
  localparam int SqW   = 2 * SideW;
  // Q2.16 coefficient times an integer square fills the key exactly, so no
  // product can exceed the key range.
  localparam int KeyW  = CoefW + SqW;
  localparam int RankW = 5;

  localparam int MaxRecords = 32;
  localparam int QueueDepth = 4;

  localparam logic [KindW-1:0] KindCircle   = 2'd0;
  localparam logic [KindW-1:0] KindSquare   = 2'd1;
  localparam logic [KindW-1:0] KindTriangle = 2'd2;

  localparam logic [CoefW-1:0] CircleCoefReset   = 18'd205887;
  localparam logic [CoefW-1:0] TriangleCoefReset = 18'd28378;
  localparam logic [CoefW-1:0] SquareCoef        = 18'd65536;

  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgCircleCoef   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTriangleCoef = 2'd1;

  typedef struct packed {
    logic [KindW-1:0] shape_kind;
    logic [SideW-1:0] side_length;
    logic             last_item;
  } in_t;

  typedef struct packed {
    logic [KindW-1:0] out_kind;
    logic [SideW-1:0] out_side;
    logic [KeyW-1:0]  area_key;
    logic [RankW-1:0] rank;
    logic             last_result;
    logic             overflow;
  } out_t;

  // One stored record
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [SideW-1:0] side;
    logic [KeyW-1:0]  key;
  } rec_t;

  // Keyed word passed from front to back
  typedef struct packed {
    rec_t rec;
    logic last;
  } qent_t;

endpackage

`default_nettype wire

FILE: rtl/sas_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sas_front: coefficient registers and area key pipeline
// Accepts input words, squares the side, then scales by the kind coefficient.
// ----------------------------------------------------------------------------
module sas_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire sas_pkg::in_t                  in_data_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [sas_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [sas_pkg::CoefW-1:0]     cfg_data_i,
  output logic                               push_o,
  output sas_pkg::qent_t                     push_data_o,
  input  wire logic                          full_i
);
  import sas_pkg::*;

  logic [CoefW-1:0] circle_coef_q, triangle_coef_q;
  logic [CoefW-1:0] coef_sel;

  logic             s1_v_q;
  logic [KindW-1:0] s1_kind_q;
  logic [SideW-1:0] s1_side_q;
  logic             s1_last_q;
  logic [SqW-1:0]   s1_sq_q;
  logic [CoefW-1:0] s1_coef_q;

  logic  s2_v_q;
  qent_t s2_q;

  logic s1_adv, s2_free, s1_free, in_acc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circle_coef_q   <= CircleCoefReset;
      triangle_coef_q <= TriangleCoefReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgCircleCoef:   circle_coef_q   <= cfg_data_i;
        CfgTriangleCoef: triangle_coef_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (in_data_i.shape_kind)
      KindCircle:   coef_sel = circle_coef_q;
      KindSquare:   coef_sel = SquareCoef;
      KindTriangle: coef_sel = triangle_coef_q;
      default:      coef_sel = '0;
    endcase
  end

  assign push_o      = s2_v_q && !full_i;
  assign push_data_o = s2_q;
  assign s2_free     = !s2_v_q || push_o;
  assign s1_adv      = s1_v_q && s2_free;
  assign s1_free     = !s1_v_q || s1_adv;
  assign in_stall_o  = !s1_free;
  assign in_acc      = in_valid_i && s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_free) s1_v_q <= in_valid_i;
      if (s2_free) s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q <= in_data_i.shape_kind;
      s1_side_q <= in_data_i.side_length;
      s1_last_q <= in_data_i.last_item;
      s1_sq_q   <= SqW'(in_data_i.side_length) * SqW'(in_data_i.side_length);
      s1_coef_q <= coef_sel;
    end
    if (s1_adv) begin
      s2_q.rec.kind <= s1_kind_q;
      s2_q.rec.side <= s1_side_q;
      s2_q.rec.key  <= KeyW'(s1_coef_q) * KeyW'(s1_sq_q);
      s2_q.last     <= s1_last_q;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sas_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sas_queue: short FIFO between key pipeline and sorter
// Lets the front keep loading while the back is busy emitting a run.
// ----------------------------------------------------------------------------
module sas_queue #(
  parameter int DEPTH = sas_pkg::QueueDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire sas_pkg::qent_t push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output sas_pkg::qent_t      head_o
);
  import sas_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  qent_t            entries_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(DEPTH - 1)) return '0;
    return p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wrap_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= wrap_inc(rd_ptr_q);
      if (push_i && !pop_i)      count_q <= count_q + CntW'(1);
      else if (pop_i && !push_i) count_q <= count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entries_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

FILE: rtl/sas_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sas_back: record store and stable selection sorter
// Stores keyed records, then per output rank scans the store for the smallest
// (key, arrival index) pair above the one last emitted.
// ----------------------------------------------------------------------------
module sas_back #(
  parameter int MAX_RECORDS = sas_pkg::MaxRecords
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  wire sas_pkg::qent_t q_head_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output sas_pkg::out_t       out_data_o
);
  import sas_pkg::*;

  localparam int IdxW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CntW = $clog2(MAX_RECORDS + 1);

  typedef enum logic [2:0] {
    StLoad = 3'b001,
    StScan = 3'b010,
    StEmit = 3'b100
  } state_e;

  state_e state_q, state_d;

  rec_t store_q [MAX_RECORDS];

  logic [CntW-1:0] count_q, count_d;
  logic            dropped_q, dropped_d;
  logic [IdxW-1:0] rank_q, rank_d;

  logic [CntW-1:0] ptr_q, ptr_d;
  logic            rd_v_q, rd_v_d;
  logic [IdxW-1:0] rd_idx_q;
  rec_t            rd_rec_q;
  logic            rd_en;

  logic            cand_v_q, cand_v_d;
  rec_t            cand_q, cand_d;
  logic [IdxW-1:0] cand_idx_q, cand_idx_d;

  logic            prev_v_q, prev_v_d;
  logic [KeyW-1:0] prev_key_q, prev_key_d;
  logic [IdxW-1:0] prev_idx_q, prev_idx_d;

  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  logic store_full, store_wr, out_free, eligible, better, final_rank;

  assign store_full = (count_q == CntW'(MAX_RECORDS));
  assign q_pop_o    = (state_q == StLoad) && q_valid_i;
  assign store_wr   = q_pop_o && !store_full;
  assign rd_en      = (state_q == StScan) && (ptr_q < count_q);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign final_rank = ((CntW'(rank_q) + CntW'(1)) == count_q);

  assign eligible = !prev_v_q || (rd_rec_q.key > prev_key_q) ||
                    ((rd_rec_q.key == prev_key_q) && (rd_idx_q > prev_idx_q));
  // Strict less-than: scan order is arrival order, so the earlier record wins ties
  assign better   = !cand_v_q || (rd_rec_q.key < cand_q.key);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    rank_d      = rank_q;
    ptr_d       = ptr_q;
    rd_v_d      = rd_en;
    cand_v_d    = cand_v_q;
    cand_d      = cand_q;
    cand_idx_d  = cand_idx_q;
    prev_v_d    = prev_v_q;
    prev_key_d  = prev_key_q;
    prev_idx_d  = prev_idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    unique case (state_q)
      StLoad: begin
        if (q_pop_o) begin
          if (store_full) dropped_d = 1'b1;
          else            count_d   = count_q + CntW'(1);
          if (q_head_i.last) begin
            // A set always holds at least one record here
            state_d  = StScan;
            rank_d   = '0;
            prev_v_d = 1'b0;
            ptr_d    = '0;
            cand_v_d = 1'b0;
          end
        end
      end
      StScan: begin
        if (rd_en) ptr_d = ptr_q + CntW'(1);
        if (rd_v_q && eligible && better) begin
          cand_v_d   = 1'b1;
          cand_d     = rd_rec_q;
          cand_idx_d = rd_idx_q;
        end
        if (!rd_en && !rd_v_q) state_d = StEmit;
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.out_kind    = cand_q.kind;
          out_d.out_side    = cand_q.side;
          out_d.area_key    = cand_q.key;
          out_d.rank        = RankW'(rank_q);
          out_d.last_result = final_rank;
          out_d.overflow    = dropped_q;
          prev_v_d          = 1'b1;
          prev_key_d        = cand_q.key;
          prev_idx_d        = cand_idx_q;
          if (final_rank) begin
            state_d   = StLoad;
            count_d   = '0;
            dropped_d = 1'b0;
          end else begin
            state_d  = StScan;
            rank_d   = rank_q + IdxW'(1);
            ptr_d    = '0;
            cand_v_d = 1'b0;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      rank_q      <= '0;
      ptr_q       <= '0;
      rd_v_q      <= 1'b0;
      cand_v_q    <= 1'b0;
      prev_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      rank_q      <= rank_d;
      ptr_q       <= ptr_d;
      rd_v_q      <= rd_v_d;
      cand_v_q    <= cand_v_d;
      prev_v_q    <= prev_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q     <= cand_d;
    cand_idx_q <= cand_idx_d;
    prev_key_q <= prev_key_d;
    prev_idx_q <= prev_idx_d;
    out_q      <= out_d;
  end

  // Record store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (store_wr) store_q[count_q[IdxW-1:0]] <= q_head_i.rec;
    if (rd_en) begin
      rd_rec_q <= store_q[ptr_q[IdxW-1:0]];
      rd_idx_q <= ptr_q[IdxW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/shape_area_sorter.sv
`timescale 1ns / 1ps
`default_nettype none
// Loading: one word per cycle unless in_stall_o holds it; an accepted word is registered
// in the square and key stages, then pushed into the sorter queue when it is not full.
// Output: for a set of n records, each result costs one scan of the record store through
// its single read port, so a run costs n scans. Words of the next set keep loading into
// the queue while a run is emitted. Reset (rst_ni low, asynchronous) empties the set,
// clears the drop flag and restores the default circle and triangle coefficients.
// ----------------------------------------------------------------------------
// shape_area_sorter: collects shape records and emits them sorted by area
// Front computes area keys, a short queue decouples it from the sorting back.
// ----------------------------------------------------------------------------
module shape_area_sorter #(
  parameter int MAX_RECORDS = sas_pkg::MaxRecords,
  parameter int QUEUE_DEPTH = sas_pkg::QueueDepth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire sas_pkg::in_t                in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output sas_pkg::out_t                    out_data_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [sas_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [sas_pkg::CoefW-1:0]   cfg_data_i
);
  import sas_pkg::*;

  logic  push, q_full, pop, q_valid;
  qent_t push_data, q_head;

  sas_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (q_full)
  );

  sas_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  sas_back #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: rtl/sas_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sas_checker: port-level checks for the shape area sorter
// Watches stalled-word hold, rank sequencing, key ordering and square keys on the result channel, and config readiness.
// ----------------------------------------------------------------------------
module sas_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_stall_o,
  input  wire sas_pkg::in_t                in_data_i,
  input  wire logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  input  wire sas_pkg::out_t               out_data_o,
  input  wire logic                        cfg_valid_i,
  input  wire logic                        cfg_ready_o,
  input  wire logic [sas_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [sas_pkg::CoefW-1:0]   cfg_data_i
);
  import sas_pkg::*;

  logic [RankW-1:0] exp_rank_q;
  logic [KeyW-1:0]  prev_key_q;
  logic             out_acc, in_acc, cfg_acc;
  logic [SqW-1:0]   side_sq;

  assign out_acc = out_valid_o && !out_stall_i;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign side_sq = SqW'(out_data_o.out_side) * SqW'(out_data_o.out_side);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_rank_q <= '0;
      prev_key_q <= '0;
    end else if (out_acc) begin
      exp_rank_q <= out_data_o.last_result ? '0 : out_data_o.rank + RankW'(1);
      prev_key_q <= out_data_o.area_key;
    end
  end

  // Stalled result words hold
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  a_rank_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.rank == exp_rank_q)
    else $error("result rank out of sequence");

  a_key_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exp_rank_q != '0 |-> out_data_o.area_key >= prev_key_q)
    else $error("area keys not ascending within a run");

  a_square_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_kind == KindSquare
      |-> out_data_o.area_key == {2'b00, side_sq, 16'h0000})
    else $error("square key is not side squared");

  // Config port takes a write in any cycle
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write offered while not ready");

  logic unused_in;
  assign unused_in = in_acc ^ cfg_acc ^ (|in_data_i) ^ (|cfg_index_i) ^ (|cfg_data_i);

endmodule

bind shape_area_sorter sas_checker u_sas_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_index_i (cfg_index_i),
  .cfg_data_i  (cfg_data_i)
);

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the shape area sorter
// Streams sets of shape records through the block and checks every sorted
// result against a cycle-free area/sort model held in a scoreboard object.
// Covers coefficient extremes, equal keys, store overflow and back pressure.
// ----------------------------------------------------------------------------
module tb;
  import sas_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 40;
  localparam int RandomWords  = 130;
  localparam int HoldCycles   = 400;
  localparam logic [63:0] KeyMax = (64'd1 << KeyW) - 64'd1;
  localparam logic [CoefW-1:0] CoefMax = {CoefW{1'b1}};
  localparam logic [KindW-1:0] KindUnused = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpare3 = 2'd3;

  // Area keys and stable sort order for the records of one set
  class area_scoreboard;
    logic [CoefW-1:0] circle_coef;
    logic [CoefW-1:0] tri_coef;
    rec_t set_q[$];
    bit dropped;
    out_t sorted_q[$];
    int errors;
    int checked;
    int sets_done;
    int overflow_sets;

    function new();
      circle_coef = CircleCoefReset;
      tri_coef = TriangleCoefReset;
      dropped = 1'b0;
    endfunction

    function void set_coef(logic [CfgIdxW-1:0] idx, logic [CoefW-1:0] val);
      case (idx)
        CfgCircleCoef: circle_coef = val;
        CfgTriangleCoef: tri_coef = val;
        default: ;
      endcase
    endfunction

    function logic [KeyW-1:0] area_of(logic [KindW-1:0] kind, logic [SideW-1:0] side);
      logic [CoefW-1:0] coef;
      logic [63:0] prod;
      case (kind)
        KindCircle: coef = circle_coef;
        KindSquare: coef = SquareCoef;
        KindTriangle: coef = tri_coef;
        default: coef = '0;
      endcase
      prod = 64'(coef) * 64'(side) * 64'(side);
      if (prod > KeyMax) prod = KeyMax;
      return prod[KeyW-1:0];
    endfunction

    function int pending();
      return sorted_q.size();
    endfunction

    function void note_word(in_t w);
      rec_t r;
      rec_t ord[MaxRecords];
      out_t e;
      int n;
      int j;
      if (set_q.size() < MaxRecords) begin
        r.kind = w.shape_kind;
        r.side = w.side_length;
        r.key = area_of(w.shape_kind, w.side_length);
        set_q.push_back(r);
      end else begin
        dropped = 1'b1;
      end
      if (!w.last_item) return;
      n = set_q.size();
      // insert in arrival order; move only past strictly greater keys
      for (int i = 0; i < n; i++) begin
        j = i;
        while (j > 0 && ord[j-1].key > set_q[i].key) begin
          ord[j] = ord[j-1];
          j--;
        end
        ord[j] = set_q[i];
      end
      for (int i = 0; i < n; i++) begin
        e.out_kind = ord[i].kind;
        e.out_side = ord[i].side;
        e.area_key = ord[i].key;
        e.rank = RankW'(i);
        e.last_result = (i == n - 1);
        e.overflow = dropped;
        sorted_q.push_back(e);
      end
      sets_done++;
      if (dropped) overflow_sets++;
      set_q.delete();
      dropped = 1'b0;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (sorted_q.size() == 0) begin
        $error("result word with nothing expected: %p", got);
        errors++;
        return;
      end
      want = sorted_q.pop_front();
      checked++;
      compare_field("out_kind", 64'(want.out_kind), 64'(got.out_kind));
      compare_field("out_side", 64'(want.out_side), 64'(got.out_side));
      compare_field("area_key", 64'(want.area_key), 64'(got.area_key));
      compare_field("rank", 64'(want.rank), 64'(got.rank));
      compare_field("last_result", 64'(want.last_result), 64'(got.last_result));
      compare_field("overflow", 64'(want.overflow), 64'(got.overflow));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CoefW-1:0] cfg_data_i = '0;

  area_scoreboard sb;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int words_sent = 0;
  int coef_writes = 0;
  bit set_open = 1'b0;

  shape_area_sorter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  function automatic in_t mk(logic [KindW-1:0] kind, logic [SideW-1:0] side, logic fin);
    in_t w;
    w.shape_kind = kind;
    w.side_length = side;
    w.last_item = fin;
    return w;
  endfunction

  function automatic in_t random_record(logic fin);
    logic [KindW-1:0] kind;
    logic [SideW-1:0] side;
    int pick;
    kind = ($urandom_range(9) == 0) ? KindUnused : KindW'($urandom_range(2));
    pick = $urandom_range(9);
    // bias toward extremes and small sides so equal keys show up
    if (pick == 0) side = '0;
    else if (pick == 1) side = '1;
    else if (pick < 4) side = SideW'($urandom_range(1, 3));
    else side = SideW'($urandom_range(255));
    return mk(kind, side, fin);
  endfunction

  task automatic send_record(in_t w);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic send_set(int n, bit close);
    for (int i = 0; i < n; i++) send_record(random_record(close && i == n - 1));
    set_open = !close;
  endtask

  task automatic write_coef(logic [CfgIdxW-1:0] idx, logic [CoefW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_coef(idx, val);
    coef_writes++;
    // idle after the write so a following write starts on a fresh edge
    @(posedge clk_i);
  endtask

  // Drop valid, drain all expected words, then let the pipeline go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int target;
    int phase;
    int nsets;
    int size;
    bit close;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // Reset coefficients: every used kind at the largest side, then the unused kind, mid, small and zero sides
    send_record(mk(KindCircle, 8'd255, 1'b0));
    send_record(mk(KindSquare, 8'd255, 1'b0));
    send_record(mk(KindTriangle, 8'd255, 1'b0));
    send_record(mk(KindUnused, 8'd200, 1'b0));
    send_record(mk(KindSquare, 8'd0, 1'b0));
    send_record(mk(KindCircle, 8'd1, 1'b0));
    send_record(mk(KindTriangle, 8'd128, 1'b0));
    send_record(mk(KindSquare, 8'd1, 1'b1));
    // Equal keys must come out in arrival order
    send_record(mk(KindSquare, 8'd5, 1'b0));
    send_record(mk(KindUnused, 8'd9, 1'b0));
    send_record(mk(KindSquare, 8'd5, 1'b0));
    send_record(mk(KindCircle, 8'd0, 1'b0));
    send_record(mk(KindSquare, 8'd5, 1'b1));
    send_record(mk(KindTriangle, 8'd255, 1'b1));
    settle();

    write_coef(CfgCircleCoef, CoefMax);
    write_coef(CfgTriangleCoef, CoefMax);
    send_record(mk(KindCircle, 8'd255, 1'b0));
    send_record(mk(KindTriangle, 8'd255, 1'b0));
    send_record(mk(KindSquare, 8'd255, 1'b1));
    settle();

    write_coef(CfgCircleCoef, '0);
    write_coef(CfgTriangleCoef, '0);
    write_coef(CfgSpare2, CoefMax);
    write_coef(CfgSpare3, CoefMax);
    send_record(mk(KindCircle, 8'd7, 1'b0));
    send_record(mk(KindTriangle, 8'd7, 1'b0));
    send_record(mk(KindSquare, 8'd0, 1'b0));
    send_record(mk(KindUnused, 8'd3, 1'b1));
    settle();

    // Change coefficients with half a set already stored
    write_coef(CfgCircleCoef, CircleCoefReset);
    write_coef(CfgTriangleCoef, TriangleCoefReset);
    send_record(mk(KindCircle, 8'd10, 1'b0));
    send_record(mk(KindTriangle, 8'd10, 1'b0));
    settle();
    write_coef(CfgCircleCoef, 18'd1000);
    write_coef(CfgTriangleCoef, 18'd250000);
    send_record(mk(KindCircle, 8'd10, 1'b0));
    send_record(mk(KindTriangle, 8'd10, 1'b1));
    settle();

    target = words_sent + RandomWords;
    phase = 0;
    while (words_sent < target) begin
      case (phase % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 46; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 46; end
        default: begin gap_pct = 14; stall_pct = 14; end
      endcase
      settle();
      case (phase % 5)
        0: begin
          write_coef(CfgCircleCoef, CoefW'($urandom_range(262143)));
          write_coef(CfgTriangleCoef, CoefW'($urandom_range(262143)));
        end
        1: begin
          write_coef(CfgCircleCoef, CircleCoefReset);
          write_coef(CfgTriangleCoef, TriangleCoefReset);
        end
        2: begin
          write_coef(CfgCircleCoef, CoefMax);
          write_coef(CfgTriangleCoef, CoefMax);
        end
        3: begin
          write_coef(CfgCircleCoef, '0);
          write_coef(CfgTriangleCoef, CoefW'($urandom_range(262143)));
        end
        default: begin
          write_coef(CfgCircleCoef, CoefW'($urandom_range(262143)));
          write_coef(CfgTriangleCoef, CoefMax);
        end
      endcase
      // hold the output while the next set piles up behind it
      if (phase == 2) hold_req = HoldCycles;
      nsets = $urandom_range(2, 4);
      for (int s = 0; s < nsets; s++) begin
        if (s == 0 && (phase == 1 || phase == 5)) size = $urandom_range(33, 36);
        else if (s == 1 && phase == 2) size = 20;
        else size = $urandom_range(1, 12);
        close = (s < nsets - 1) || ($urandom_range(3) != 0);
        send_set(size, close);
      end
      phase++;
    end
    if (set_open) send_record(random_record(1'b1));
    settle();

    $display("Checked %0d sorted words from %0d records in %0d sets (%0d overflowed).",
             sb.checked, words_sent, sb.sets_done, sb.overflow_sets);
    $display("Coefficients written %0d times, extremes and mid-set changes included.",
             coef_writes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/sas_pkg.sv
rtl/sas_front.sv
rtl/sas_queue.sv
rtl/sas_back.sv
rtl/shape_area_sorter.sv
rtl/sas_checker.sv
verif/tb.sv
